FILE: rtl/bb3_pkg.sv
`default_nettype none

package bb3_pkg;

  // field widths
  localparam int PIX_BITS      = 8;
  localparam int W_BITS        = 11;
  localparam int H_BITS        = 16;
  localparam int POS_BITS      = W_BITS + H_BITS;
  localparam int ROW_POS_BITS  = POS_BITS - 1;
  localparam int SUM_BITS      = 12;
  localparam int CNT9_BITS     = 4;
  localparam int RECIP_BITS    = 21;
  localparam int RECIP_SHIFT   = 20;
  localparam int PROD_BITS     = SUM_BITS + RECIP_BITS;
  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = 16;
  localparam int MIN_SIZE      = 2;

  // output queue
  localparam int OUT_DEPTH     = 8;
  localparam int FIFO_PTR_BITS = $clog2(OUT_DEPTH);
  localparam int FIFO_CNT_BITS = FIFO_PTR_BITS + 1;

  // register map
  localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_HEIGHT = 1'b1;

  localparam logic [W_BITS-1:0] WIDTH_RESET  = 11'd640;
  localparam logic [H_BITS-1:0] HEIGHT_RESET = 16'd480;

  typedef struct packed {
    logic [PIX_BITS-1:0] red;
    logic [PIX_BITS-1:0] green;
    logic [PIX_BITS-1:0] blue;
  } rgb_t;

  // per-item control handed from the position tracker to the window stage
  typedef struct packed {
    logic       due;        // item completes an output pixel
    logic [2:0] row_ok;     // rows above / centre / below inside the frame
    logic [2:0] col_ok;     // columns left / centre / right inside the frame
    logic       frame_end;
  } pos_info_t;

  typedef struct packed {
    logic [SUM_BITS-1:0]  red;
    logic [SUM_BITS-1:0]  green;
    logic [SUM_BITS-1:0]  blue;
    logic [CNT9_BITS-1:0] count;
    logic                 frame_end;
  } sum_item_t;

  typedef struct packed {
    rgb_t px;
    logic frame_end;
  } res_item_t;

  // ceil(2^20 / n); exact quotient for any numerator below 4096
  function automatic logic [RECIP_BITS-1:0] recip(input logic [CNT9_BITS-1:0] n);
    logic [RECIP_BITS-1:0] m;
    case (n)
      4'd1:    m = 21'd1048576;
      4'd2:    m = 21'd524288;
      4'd3:    m = 21'd349526;
      4'd4:    m = 21'd262144;
      4'd5:    m = 21'd209716;
      4'd6:    m = 21'd174763;
      4'd7:    m = 21'd149797;
      4'd8:    m = 21'd131072;
      4'd9:    m = 21'd116509;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/bb3_line_store.sv
`default_nettype none

module bb3_line_store
  import bb3_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                         clk,
  input  logic                         rd_en,
  input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
  input  logic                         wr_en,
  input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
  input  rgb_t                         wr_above,
  input  rgb_t                         wr_cur,
  output rgb_t                         rd_above,
  output rgb_t                         rd_cur
);

  rgb_t mem_above [MAX_WIDTH];
  rgb_t mem_cur   [MAX_WIDTH];

  rgb_t ram_above;
  rgb_t ram_cur;
  rgb_t fwd_above;
  rgb_t fwd_cur;
  logic fwd;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_above[wr_addr] <= wr_above;
      mem_cur[wr_addr]   <= wr_cur;
    end
  end

  // read-first RAM; a same-address write in the same cycle is bypassed
  always_ff @(posedge clk) begin
    if (rd_en) begin
      ram_above <= mem_above[rd_addr];
      ram_cur   <= mem_cur[rd_addr];
      fwd       <= wr_en && (wr_addr == rd_addr);
      fwd_above <= wr_above;
      fwd_cur   <= wr_cur;
    end
  end

  assign rd_above = fwd ? fwd_above : ram_above;
  assign rd_cur   = fwd ? fwd_cur   : ram_cur;

endmodule

`default_nettype wire

FILE: rtl/bb3_position.sv
`default_nettype none

module bb3_position
  import bb3_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [CFG_IDX_BITS-1:0]      cfg_addr,
  input  logic [CFG_DATA_BITS-1:0]     cfg_wdata,
  input  logic                         accept,
  output logic                         busy,
  output logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
  output logic                         s1_valid,
  output logic [$clog2(MAX_WIDTH)-1:0] s1_addr,
  output pos_info_t                    s1_info
);

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int CMPW = ((CW > W_BITS) ? CW : W_BITS) + 1;
  localparam int DCW  = $clog2(POS_BITS + 1);
  localparam int PW1  = POS_BITS + 1;
  localparam int RW1  = ROW_POS_BITS + 1;

  logic [W_BITS-1:0]       image_width;
  logic [H_BITS-1:0]       image_height;
  logic [W_BITS-1:0]       w_used;
  logic [H_BITS-1:0]       h_used;
  logic [POS_BITS-1:0]     prod;

  logic [CW-1:0]           col;
  logic [H_BITS-1:0]       row;
  logic [POS_BITS-1:0]     pos;
  logic [ROW_POS_BITS-1:0] orow;
  logic [W_BITS-1:0]       ocol;

  logic [CW-1:0]           col_next;
  logic [H_BITS-1:0]       row_next;
  logic [POS_BITS-1:0]     pos_next;
  logic [ROW_POS_BITS-1:0] orow_next;
  logic [W_BITS-1:0]       ocol_next;

  logic                    due;
  logic                    col_last;
  logic                    end_pos;
  logic                    ocol_last;
  logic [RW1-1:0]          h_ext;
  pos_info_t               info;

  logic [DCW-1:0]          div_cnt;
  logic [POS_BITS-1:0]     div_quo;
  logic [W_BITS-1:0]       div_rem;
  logic [W_BITS:0]         trial;
  logic                    div_ge;
  logic [POS_BITS-1:0]     quo_step;
  logic [W_BITS-1:0]       rem_step;

  always_comb begin
    if (CMPW'(image_width) < CMPW'(MIN_SIZE)) begin
      w_used = W_BITS'(MIN_SIZE);
    end else if (CMPW'(image_width) > CMPW'(MAX_WIDTH)) begin
      w_used = W_BITS'(MAX_WIDTH);
    end else begin
      w_used = image_width;
    end
    if (image_height < H_BITS'(MIN_SIZE)) begin
      h_used = H_BITS'(MIN_SIZE);
    end else begin
      h_used = image_height;
    end
  end

  always_ff @(posedge clk) begin
    prod <= POS_BITS'(w_used) * POS_BITS'(h_used);
  end

  always_comb begin
    h_ext     = RW1'(h_used);
    due       = (row >= H_BITS'(2)) || ((row == H_BITS'(1)) && (col != '0));
    col_last  = (CMPW'(col) + CMPW'(1)) >= CMPW'(w_used);
    end_pos   = ({1'b0, pos} + PW1'(1)) >= {1'b0, prod};
    ocol_last = ({1'b0, ocol} + (W_BITS + 1)'(1)) >= {1'b0, w_used};

    info.due       = due;
    info.row_ok[0] = (orow != '0) && (({1'b0, orow} - RW1'(1)) < h_ext);
    info.row_ok[1] = {1'b0, orow} < h_ext;
    info.row_ok[2] = ({1'b0, orow} + RW1'(1)) < h_ext;
    info.col_ok[0] = (ocol != '0);
    info.col_ok[1] = 1'b1;
    info.col_ok[2] = (col != '0) && !ocol_last;
    info.frame_end = due && end_pos;

    col_next  = col_last ? '0 : col + CW'(1);
    row_next  = row;
    if (col_last && (row != '1)) begin
      row_next = row + H_BITS'(1);
    end
    pos_next  = pos;
    orow_next = orow;
    ocol_next = ocol;
    if (due) begin
      if (end_pos) begin
        col_next  = '0;
        row_next  = '0;
        pos_next  = '0;
        orow_next = '0;
        ocol_next = '0;
      end else begin
        pos_next = pos + POS_BITS'(1);
        if (ocol_last) begin
          ocol_next = '0;
          orow_next = orow + ROW_POS_BITS'(1);
        end else begin
          ocol_next = ocol + W_BITS'(1);
        end
      end
    end
  end

  // restoring divider: output row/column = position / width, one bit per cycle
  always_comb begin
    trial    = {div_rem, div_quo[POS_BITS-1]};
    div_ge   = trial >= {1'b0, w_used};
    rem_step = div_ge ? W_BITS'(trial - {1'b0, w_used}) : W_BITS'(trial);
    quo_step = {div_quo[POS_BITS-2:0], div_ge};
  end

  assign busy    = (div_cnt != '0);
  assign rd_addr = col;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
      col          <= '0;
      row          <= '0;
      pos          <= '0;
      orow         <= '0;
      ocol         <= '0;
      s1_valid     <= 1'b0;
      div_cnt      <= DCW'(POS_BITS);
      div_quo      <= '0;
      div_rem      <= '0;
    end else begin
      s1_valid <= accept;
      if (accept) begin
        col  <= col_next;
        row  <= row_next;
        pos  <= pos_next;
        orow <= orow_next;
        ocol <= ocol_next;
      end
      if (cfg_wr_en) begin
        case (cfg_addr)
          REG_IMAGE_WIDTH:  image_width  <= cfg_wdata[W_BITS-1:0];
          REG_IMAGE_HEIGHT: image_height <= cfg_wdata[H_BITS-1:0];
          default: ;
        endcase
        div_cnt <= DCW'(POS_BITS);
        div_quo <= accept ? pos_next : pos;
        div_rem <= '0;
      end else if (busy) begin
        div_cnt <= div_cnt - DCW'(1);
        div_quo <= quo_step;
        div_rem <= rem_step;
        if (div_cnt == DCW'(1)) begin
          orow <= quo_step[ROW_POS_BITS-1:0];
          ocol <= rem_step;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_addr <= col;
      s1_info <= info;
    end
  end

  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    (accept && due && end_pos) |=>
      (col == '0) && (row == '0) && (pos == '0) && (ocol == '0) && (orow == '0))
    else $error("counters not cleared after frame end");

  a_ocol_range: assert property (@(posedge clk) disable iff (rst)
    !busy |-> ({1'b0, ocol} < {1'b0, w_used}))
    else $error("output column outside width");

endmodule

`default_nettype wire

FILE: rtl/bb3_window.sv
`default_nettype none

module bb3_window
  import bb3_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      accept,
  input  rgb_t      in_pix,
  input  logic      s1_valid,
  input  pos_info_t s1_info,
  input  rgb_t      line_above,
  input  rgb_t      line_cur,
  output rgb_t      wr_above,
  output rgb_t      wr_cur,
  output logic      s2_valid,
  output sum_item_t s2_item
);

  rgb_t                 win    [3][3];  // [row oldest..newest][col oldest..newest]
  rgb_t                 taps   [3][3];
  rgb_t                 newcol [3];
  rgb_t                 s1_pix;
  logic [SUM_BITS-1:0]  sum_r;
  logic [SUM_BITS-1:0]  sum_g;
  logic [SUM_BITS-1:0]  sum_b;
  logic [CNT9_BITS-1:0] n;

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix <= in_pix;
    end
  end

  assign newcol[0] = line_above;
  assign newcol[1] = line_cur;
  assign newcol[2] = s1_pix;

  // line stores shift down one row at this column
  assign wr_above = line_cur;
  assign wr_cur   = s1_pix;

  // left / centre / right: the two newest window columns plus the incoming one
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < 2; j++) begin
        taps[k][j] = win[k][j + 1];
      end
      taps[k][2] = newcol[k];
    end
  end

  always_comb begin
    sum_r = '0;
    sum_g = '0;
    sum_b = '0;
    n     = '0;
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < 3; j++) begin
        if (s1_info.row_ok[k] && s1_info.col_ok[j]) begin
          sum_r = sum_r + SUM_BITS'(taps[k][j].red);
          sum_g = sum_g + SUM_BITS'(taps[k][j].green);
          sum_b = sum_b + SUM_BITS'(taps[k][j].blue);
          n     = n + CNT9_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          win[k][j] <= '0;
        end
      end
      s2_valid <= 1'b0;
    end else begin
      if (s1_valid) begin
        for (int k = 0; k < 3; k++) begin
          win[k][0] <= win[k][1];
          win[k][1] <= win[k][2];
          win[k][2] <= newcol[k];
        end
      end
      s2_valid <= s1_valid && s1_info.due;
    end
  end

  // sums carry the half-divisor for round-half-up
  always_ff @(posedge clk) begin
    if (s1_valid) begin
      s2_item.red       <= sum_r + SUM_BITS'(n >> 1);
      s2_item.green     <= sum_g + SUM_BITS'(n >> 1);
      s2_item.blue      <= sum_b + SUM_BITS'(n >> 1);
      s2_item.count     <= n;
      s2_item.frame_end <= s1_info.frame_end;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/bb3_mean.sv
`default_nettype none

module bb3_mean
  import bb3_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  sum_item_t in_item,
  output logic      out_valid,
  output res_item_t out_item
);

  logic [RECIP_BITS-1:0] m;
  logic [PROD_BITS-1:0]  pr_r;
  logic [PROD_BITS-1:0]  pr_g;
  logic [PROD_BITS-1:0]  pr_b;

  // divide by the tap count through a reciprocal multiply
  always_comb begin
    m    = recip(in_item.count);
    pr_r = PROD_BITS'(in_item.red)   * PROD_BITS'(m);
    pr_g = PROD_BITS'(in_item.green) * PROD_BITS'(m);
    pr_b = PROD_BITS'(in_item.blue)  * PROD_BITS'(m);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      out_item.px.red    <= pr_r[RECIP_SHIFT +: PIX_BITS];
      out_item.px.green  <= pr_g[RECIP_SHIFT +: PIX_BITS];
      out_item.px.blue   <= pr_b[RECIP_SHIFT +: PIX_BITS];
      out_item.frame_end <= in_item.frame_end;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/bb3_out_fifo.sv
`default_nettype none

module bb3_out_fifo
  import bb3_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  input  res_item_t                push_item,
  input  logic                     pop,
  output logic                     out_valid,
  output res_item_t                out_item,
  output logic [FIFO_CNT_BITS-1:0] count
);

  res_item_t                mem [OUT_DEPTH];
  logic [FIFO_PTR_BITS-1:0] wr_ptr;
  logic [FIFO_PTR_BITS-1:0] rd_ptr;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + FIFO_PTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_PTR_BITS'(1);
      end
      count <= count + FIFO_CNT_BITS'(push) - FIFO_CNT_BITS'(pop);
    end
  end

  assign out_valid = (count != '0);
  assign out_item  = mem[rd_ptr];

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count < FIFO_CNT_BITS'(OUT_DEPTH)) || pop)
    else $error("output queue overflow");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FIFO_CNT_BITS'(OUT_DEPTH))
    else $error("output queue count out of range");

endmodule

`default_nettype wire

FILE: rtl/box_blur_3x3_rgb.sv
`default_nettype none

// 3x3 box blur over RGB raster input; a result pixel is due one row plus one pixel after its own.
// Path: the completing item is registered in stages 0, 1 and 2, then waits in the output queue.
// Throughput: 1 item per cycle while s_axis_tready is high, set by one line store read plus
//   one write per pixel; tready drops while the position divider runs, or when results in
//   flight plus the 8-entry output queue reach 8. Reset (rst, sync, active high): counters,
//   window, queue clear, size 640x480; tready stays low for the divider, as after any cfg write.
module box_blur_3x3_rgb
  import bb3_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                     clk,
  input  logic                     rst,

  input  logic                     cfg_wr_en,
  input  logic [CFG_IDX_BITS-1:0]  cfg_addr,   // 0 image_width, 1 image_height
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata,

  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [23:0]              s_axis_tdata,   // in_red[7:0], in_green, in_blue
  input  logic                     s_axis_tuser,   // command: 1 = flush item

  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [23:0]              m_axis_tdata,   // out_red[7:0], out_green, out_blue
  output logic                     m_axis_tlast    // frame_end
);

  localparam int AW    = $clog2(MAX_WIDTH);
  localparam int LOADW = FIFO_CNT_BITS + 1;

  logic                     accept;
  logic                     busy;
  rgb_t                     in_pix;

  logic [AW-1:0]            rd_addr;
  logic                     s1_valid;
  logic [AW-1:0]            s1_addr;
  pos_info_t                s1_info;

  rgb_t                     line_above;
  rgb_t                     line_cur;
  rgb_t                     wr_above;
  rgb_t                     wr_cur;

  logic                     s2_valid;
  sum_item_t                s2_item;
  logic                     mean_valid;
  res_item_t                mean_item;

  res_item_t                fifo_item;
  logic [FIFO_CNT_BITS-1:0] fifo_count;
  logic                     pop;
  logic [LOADW-1:0]         load;

  // flush items enter the window as black pixels
  always_comb begin
    in_pix = '0;
    if (!s_axis_tuser) begin
      in_pix.red   = s_axis_tdata[7:0];
      in_pix.green = s_axis_tdata[15:8];
      in_pix.blue  = s_axis_tdata[23:16];
    end
  end

  // credit: every result already in flight holds a queue slot, so the
  // fixed-latency pipeline behind the input never has to stall
  assign load = LOADW'(fifo_count) + LOADW'(s1_valid && s1_info.due)
              + LOADW'(s2_valid) + LOADW'(mean_valid);

  assign s_axis_tready = !busy && (load < LOADW'(OUT_DEPTH));
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign pop           = m_axis_tvalid && m_axis_tready;

  // stage 0: counters, frame geometry and line store address
  bb3_position #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_position (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .busy      (busy),
    .rd_addr   (rd_addr),
    .s1_valid  (s1_valid),
    .s1_addr   (s1_addr),
    .s1_info   (s1_info)
  );

  // two rows of history, read at accept, written back in the cycle after
  bb3_line_store #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_store (
    .clk      (clk),
    .rd_en    (accept),
    .rd_addr  (rd_addr),
    .wr_en    (s1_valid),
    .wr_addr  (s1_addr),
    .wr_above (wr_above),
    .wr_cur   (wr_cur),
    .rd_above (line_above),
    .rd_cur   (line_cur)
  );

  // stage 1: window shift and masked neighborhood sums
  bb3_window u_window (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .in_pix     (in_pix),
    .s1_valid   (s1_valid),
    .s1_info    (s1_info),
    .line_above (line_above),
    .line_cur   (line_cur),
    .wr_above   (wr_above),
    .wr_cur     (wr_cur),
    .s2_valid   (s2_valid),
    .s2_item    (s2_item)
  );

  // stage 2: rounded mean per channel
  bb3_mean u_mean (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s2_valid),
    .in_item   (s2_item),
    .out_valid (mean_valid),
    .out_item  (mean_item)
  );

  // stage 3: output queue decouples m_axis backpressure
  bb3_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (mean_valid),
    .push_item (mean_item),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_item  (fifo_item),
    .count     (fifo_count)
  );

  assign m_axis_tdata = {fifo_item.px.blue, fifo_item.px.green, fifo_item.px.red};
  assign m_axis_tlast = fifo_item.frame_end;

endmodule

`default_nettype wire
